>>> rtl/core/utf8_validate_crlf_normalize_unit_defines.svh
// ---------------------------------------------------------------------------
// utf8_validate_crlf_normalize_unit assertion macros
// concurrent check helpers used by the utf8 validator top
// ---------------------------------------------------------------------------
`ifndef UTF8_VALIDATE_CRLF_NORMALIZE_UNIT_DEFINES_SVH
`define UTF8_VALIDATE_CRLF_NORMALIZE_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define U8V_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("utf8v check failed");

// next-cycle implication, disabled while reset is asserted
`define U8V_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("utf8v check failed");

`endif

>>> rtl/core/utf8v_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// utf8v_pkg
// types, byte constants and lead classification for the utf8 validator
// ---------------------------------------------------------------------------
package utf8v_pkg;

    typedef enum logic [2:0] {
        ERR_OK        = 3'd0,
        ERR_TRUNCATED = 3'd1,
        ERR_BAD_CONT  = 3'd2,
        ERR_OVERLONG  = 3'd3,
        ERR_SURROGATE = 3'd4,
        ERR_ABOVE_MAX = 3'd5,
        ERR_BAD_LEAD  = 3'd6
    } t_err;

    // number of continuation bytes after a lead, or a bad lead
    typedef enum logic [2:0] {
        CLS_ASCII = 3'd0,
        CLS_CONT1 = 3'd1,
        CLS_CONT2 = 3'd2,
        CLS_CONT3 = 3'd3,
        CLS_BAD   = 3'd4
    } t_lead_cls;

    localparam logic [7:0] BYTE_LF        = 8'h0A;
    localparam logic [7:0] BYTE_CR        = 8'h0D;
    localparam logic [7:0] LEAD2_LO       = 8'hC2;
    localparam logic [7:0] LEAD2_HI       = 8'hDF;
    localparam logic [7:0] LEAD3_LO       = 8'hE0;
    localparam logic [7:0] LEAD3_HI       = 8'hEF;
    localparam logic [7:0] LEAD4_LO       = 8'hF0;
    localparam logic [7:0] LEAD4_HI       = 8'hF4;
    localparam logic [7:0] LEAD_SURR      = 8'hED;
    localparam logic [7:0] CONT_MASK      = 8'hC0;
    localparam logic [7:0] CONT_TAG       = 8'h80;
    localparam logic [7:0] E0_MIN_CONT    = 8'hA0;
    localparam logic [7:0] SURR_MIN_CONT  = 8'hA0;
    localparam logic [7:0] F0_MIN_CONT    = 8'h90;
    localparam logic [7:0] F4_MAX_CONT    = 8'h8F;
    localparam logic [7:0] BOM_B0         = 8'hEF;
    localparam logic [7:0] BOM_B1         = 8'hBB;
    localparam logic [7:0] BOM_B2         = 8'hBF;

    localparam int unsigned BURST_BYTES = 4;
    localparam int unsigned QUEUE_DEPTH = 2;

    // one queue entry: the result beats caused by one input beat
    typedef struct packed {
        logic [1:0]                   last_idx;
        logic                         has_byte;
        logic [BURST_BYTES-1:0][7:0]  bytes;
        logic                         eot;
        t_err                         err;
        logic [31:0]                  offset;
    } t_burst;

    function automatic t_lead_cls lead_class(input logic [7:0] b);
        t_lead_cls c;
        case (b) inside
            [8'h00:8'h7F]:       c = CLS_ASCII;
            [LEAD2_LO:LEAD2_HI]: c = CLS_CONT1;
            [LEAD3_LO:LEAD3_HI]: c = CLS_CONT2;
            [LEAD4_LO:LEAD4_HI]: c = CLS_CONT3;
            default:             c = CLS_BAD;
        endcase
        return c;
    endfunction

endpackage

>>> rtl/core/utf8v_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// utf8v_front
// takes input beats, tracks sequence state and builds result bursts
// ---------------------------------------------------------------------------
module utf8v_front #(
    parameter int OFFSET_BITS = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    input  logic             i_full,
    output logic             o_push,
    output utf8v_pkg::t_burst o_burst
);
    import utf8v_pkg::*;

    logic [7:0]             r_held [3];
    logic [7:0]             n_held [3];
    logic [1:0]             r_need, n_need;
    t_err                   r_fault, n_fault;
    logic [OFFSET_BITS-1:0] r_lead_off, n_lead_off;
    logic [OFFSET_BITS-1:0] r_count, n_count;
    logic                   r_pcr, n_pcr;
    t_err                   r_err, n_err;
    logic                   r_start, n_start;

    logic                   accept;
    logic [2:0]             e_cnt;
    logic [BURST_BYTES-1:0][7:0] e_bytes;
    t_lead_cls              cls;
    t_lead_cls              held_cls;
    logic [1:0]             cont_n;
    logic [1:0]             pos;
    logic [63:0]            off_wide;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_held     = r_held;
        n_need     = r_need;
        n_fault    = r_fault;
        n_lead_off = r_lead_off;
        n_count    = r_count;
        n_pcr      = r_pcr;
        n_err      = r_err;
        n_start    = r_start;
        e_cnt      = 3'd0;
        e_bytes    = '0;
        cls        = lead_class(i_byte);
        held_cls   = lead_class(r_held[0]);
        cont_n     = (held_cls == CLS_ASCII || held_cls == CLS_BAD) ? 2'd1
                                                                    : held_cls[1:0];
        pos        = 2'(cont_n - r_need + 2'd1);
        if (r_err == ERR_OK) begin
            if (r_need == 2'd0) begin
                if (r_pcr) begin
                    // a waiting cr leaves as lf once the next lead shows up
                    n_pcr      = 1'b0;
                    e_bytes[0] = BYTE_LF;
                    e_cnt      = 3'd1;
                end
                if (r_pcr && i_byte == BYTE_LF) begin
                    n_count = r_count + OFFSET_BITS'(1);
                    n_start = 1'b0;
                end else begin
                    n_lead_off = r_count;
                    n_count    = r_count + OFFSET_BITS'(1);
                    case (cls)
                        CLS_ASCII: begin
                            if (i_byte == BYTE_CR) begin
                                n_pcr = 1'b1;
                            end else begin
                                e_bytes[e_cnt[1:0]] = i_byte;
                                e_cnt               = e_cnt + 3'd1;
                            end
                            n_start = 1'b0;
                        end
                        CLS_CONT1, CLS_CONT2, CLS_CONT3: begin
                            n_held[0] = i_byte;
                            n_need    = cls[1:0];
                            n_fault   = ERR_OK;
                        end
                        default: begin
                            n_err   = ERR_BAD_LEAD;
                            n_start = 1'b0;
                        end
                    endcase
                end
            end else begin
                n_count = r_count + OFFSET_BITS'(1);
                if ((i_byte & CONT_MASK) != CONT_TAG) begin
                    n_fault = ERR_BAD_CONT;
                end else if (pos == 2'd1 && r_fault == ERR_OK) begin
                    if (r_held[0] == LEAD3_LO && i_byte < E0_MIN_CONT) begin
                        n_fault = ERR_OVERLONG;
                    end else if (r_held[0] == LEAD_SURR && i_byte >= SURR_MIN_CONT) begin
                        n_fault = ERR_SURROGATE;
                    end else if (r_held[0] == LEAD4_LO && i_byte < F0_MIN_CONT) begin
                        n_fault = ERR_OVERLONG;
                    end else if (r_held[0] == LEAD4_HI && i_byte > F4_MAX_CONT) begin
                        n_fault = ERR_ABOVE_MAX;
                    end
                end
                if (r_need > 2'd1) begin
                    if (pos != 2'd3) begin
                        n_held[pos] = i_byte;
                    end
                    n_need = r_need - 2'd1;
                end else begin
                    n_need = 2'd0;
                    if (n_fault != ERR_OK) begin
                        n_err = n_fault;
                    end else if (r_start && cont_n == 2'd2 && r_held[0] == BOM_B0 &&
                                 r_held[1] == BOM_B1 && i_byte == BOM_B2) begin
                        // leading byte order mark, offsets restart after it
                        n_count = '0;
                    end else begin
                        for (int i = 0; i < BURST_BYTES; i++) begin
                            if (i < 3 && 2'(i) < cont_n) begin
                                e_bytes[2'(i)] = r_held[2'(i)];
                            end else if (2'(i) == cont_n) begin
                                e_bytes[2'(i)] = i_byte;
                            end
                        end
                        e_cnt = {1'b0, cont_n} + 3'd1;
                    end
                    n_start = 1'b0;
                end
            end
        end
        if (i_last && n_err == ERR_OK) begin
            if (n_need != 2'd0) begin
                n_err = ERR_TRUNCATED;
            end else if (n_pcr) begin
                e_bytes[e_cnt[1:0]] = BYTE_LF;
                e_cnt               = e_cnt + 3'd1;
            end
        end
    end

    assign off_wide = 64'(n_lead_off);

    always_comb begin
        o_push            = accept && (i_last || e_cnt != 3'd0);
        o_burst.bytes     = e_bytes;
        o_burst.has_byte  = (e_cnt != 3'd0);
        o_burst.last_idx  = (e_cnt == 3'd0) ? 2'd0 : 2'(e_cnt - 3'd1);
        o_burst.eot       = i_last;
        o_burst.err       = i_last ? n_err : ERR_OK;
        o_burst.offset    = (i_last && n_err != ERR_OK) ? off_wide[31:0] : 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_need     <= 2'd0;
            r_fault    <= ERR_OK;
            r_lead_off <= '0;
            r_count    <= '0;
            r_pcr      <= 1'b0;
            r_err      <= ERR_OK;
            r_start    <= 1'b1;
        end else if (accept) begin
            if (i_last) begin
                r_need     <= 2'd0;
                r_fault    <= ERR_OK;
                r_lead_off <= '0;
                r_count    <= '0;
                r_pcr      <= 1'b0;
                r_err      <= ERR_OK;
                r_start    <= 1'b1;
            end else begin
                r_need     <= n_need;
                r_fault    <= n_fault;
                r_lead_off <= n_lead_off;
                r_count    <= n_count;
                r_pcr      <= n_pcr;
                r_err      <= n_err;
                r_start    <= n_start;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_held <= n_held;
        end
    end

endmodule

>>> rtl/core/utf8v_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// utf8v_queue
// two-entry burst queue between the front and back parts
// ---------------------------------------------------------------------------
module utf8v_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  utf8v_pkg::t_burst i_data,
    output logic              o_full,
    output logic              o_valid,
    output utf8v_pkg::t_burst o_head,
    input  logic              i_pop
);
    import utf8v_pkg::*;

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

    t_burst              r_mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] r_wr, r_rd;
    logic [PTR_BITS:0]   r_level;
    logic                do_push, do_pop;

    assign o_full  = (r_level == (PTR_BITS+1)'(QUEUE_DEPTH));
    assign o_valid = (r_level != '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + PTR_BITS'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + PTR_BITS'(1);
            end
            if (do_push && !do_pop) begin
                r_level <= r_level + (PTR_BITS+1)'(1);
            end else if (do_pop && !do_push) begin
                r_level <= r_level - (PTR_BITS+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

>>> rtl/core/utf8v_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// utf8v_back
// splits queued bursts into single result beats on an output register
// ---------------------------------------------------------------------------
module utf8v_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_head_valid,
    input  utf8v_pkg::t_burst i_head,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [7:0]        o_byte,
    output logic              o_has_byte,
    output logic              o_eot,
    output logic [2:0]        o_err,
    output logic [31:0]       o_offset
);
    import utf8v_pkg::*;

    logic [1:0]  r_idx;
    logic        r_valid;
    logic [7:0]  r_byte;
    logic        r_has_byte;
    logic        r_eot;
    t_err        r_err;
    logic [31:0] r_offset;
    logic        load;
    logic        at_end;

    assign load   = i_head_valid && (!r_valid || i_ready);
    assign at_end = (r_idx == i_head.last_idx);
    assign o_pop  = load && at_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_idx   <= at_end ? 2'd0 : r_idx + 2'd1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte     <= i_head.bytes[r_idx];
            r_has_byte <= i_head.has_byte;
            r_eot      <= i_head.eot && at_end;
            r_err      <= at_end ? i_head.err : ERR_OK;
            r_offset   <= at_end ? i_head.offset : 32'd0;
        end
    end

    assign o_valid    = r_valid;
    assign o_byte     = r_byte;
    assign o_has_byte = r_has_byte;
    assign o_eot      = r_eot;
    assign o_err      = r_err;
    assign o_offset   = r_offset;

endmodule

>>> rtl/core/utf8_validate_crlf_normalize_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// utf8_validate_crlf_normalize_unit
// strict utf-8 checker with byte order mark removal and cr/crlf to lf
// ---------------------------------------------------------------------------
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_in_byte, i_in_last
//  out     | output    | o_out_valid / i_out_ready  | o_out_byte .. o_error_offset
//
//  an input beat is taken whenever the burst queue has room
//  each input beat yields zero to four output beats, one per cycle from the back
//  part while the output is not stalled, so sustained rate is set by the output
//  register; an input beat passes a queue entry and then the output register
//  synchronous active-low reset clears control state, no clearing pass needed
//  either side may stall on its own: the two-entry queue absorbs the difference
//
module utf8_validate_crlf_normalize_unit #(
    parameter int OFFSET_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input beats
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_last,
    // result beats
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_has_byte,
    output logic        o_end_of_text,
    output logic [2:0]  o_error_code,
    output logic [31:0] o_error_offset
);
    import utf8v_pkg::*;

    `include "utf8_validate_crlf_normalize_unit_defines.svh"

    // front to queue
    logic   push;
    t_burst push_data;
    logic   q_full;
    // queue to back
    logic   head_valid;
    t_burst head;
    logic   pop;

    // front: decode, fault tracking, bom strip, line-end folding
    utf8v_front #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_byte  (i_in_byte),
        .i_last  (i_in_last),
        .i_full  (q_full),
        .o_push  (push),
        .o_burst (push_data)
    );

    // slack for bursts of up to four result beats
    utf8v_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_full  (q_full),
        .o_valid (head_valid),
        .o_head  (head),
        .i_pop   (pop)
    );

    // back: one result beat per cycle into the output register while not stalled
    utf8v_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_byte       (o_out_byte),
        .o_has_byte   (o_has_byte),
        .o_eot        (o_end_of_text),
        .o_err        (o_error_code),
        .o_offset     (o_error_offset)
    );

    // a result without a text byte only ever closes a text
    `U8V_ASSERT_NOW(a_empty_is_end, i_clk, i_rst_n, o_out_valid && !o_has_byte, o_end_of_text)
    // error fields stay clear on beats inside a text
    `U8V_ASSERT_NOW(a_mid_no_err, i_clk, i_rst_n, o_out_valid && !o_end_of_text,
                    o_error_code == ERR_OK && o_error_offset == 32'd0)
    // a clean end carries no offset
    `U8V_ASSERT_NOW(a_ok_no_off, i_clk, i_rst_n, o_out_valid && o_error_code == ERR_OK,
                    o_error_offset == 32'd0)
    // no push is ever dropped on a full queue
    `U8V_ASSERT_NOW(a_no_push_full, i_clk, i_rst_n, push, !q_full)

endmodule
